/* sv/bsfm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfm_pkg - shared types and constants of the break/sync frame master
// Item and result layouts, opcode and phase codes, register indexes and
// reset values used by every file of the block.
// ----------------------------------------------------------------------------
package bsfm_pkg;

  localparam int unsigned MaxFrameDef = 16;

  localparam int unsigned OpW     = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LoadIdxW = 4;
  localparam int unsigned LenW    = 5;
  localparam int unsigned TickW   = 16;
  localparam int unsigned CfgIdxW = 1;

  // Slots that the load index can reach
  localparam int unsigned LoadSlots = 2 ** LoadIdxW;

  localparam logic [ByteW-1:0] SyncByte       = 8'h55;
  localparam logic [TickW-1:0] BreakTicksRst  = 16'd677;
  localparam logic [TickW-1:0] TimeoutTicksRst = 16'd1250;
  localparam logic [TickW-1:0] TickMax        = '1;

  typedef enum logic [OpW-1:0] {
    OpStart   = 3'd0,
    OpTick    = 3'd1,
    OpTxReady = 3'd2,
    OpRxByte  = 3'd3,
    OpLoad    = 3'd4,
    OpReqAck  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    PhBreak = 2'd0,
    PhSync  = 2'd1,
    PhRecv  = 2'd2,
    PhIdle  = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBreakTicks   = 1'd0,
    CfgTimeoutTicks = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [OpW-1:0]      opcode;
    logic [ByteW-1:0]    data_byte;
    logic [LoadIdxW-1:0] load_index;
    logic [LenW-1:0]     tx_length;
    logic [LenW-1:0]     rx_length;
  } item_t;

  typedef struct packed {
    logic                line_high;
    logic                tx_valid;
    logic [ByteW-1:0]    tx_byte;
    logic                tx_stop;
    logic                rx_write;
    logic [LoadIdxW-1:0] rx_slot;
    logic [ByteW-1:0]    received_byte;
    logic                frame_done;
    logic [LenW-1:0]     frame_count;
    logic                request_valid;
    logic [1:0]          mode;
  } result_t;

  // Transmit buffer write request
  typedef struct packed {
    logic                en;
    logic [LoadIdxW-1:0] idx;
    logic [ByteW-1:0]    data;
  } buf_wr_t;

endpackage

/* sv/bsfm_item_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfm_item_if - input item channel
// Valid/ready channel carrying one event item.
// ----------------------------------------------------------------------------
interface bsfm_item_if
  import bsfm_pkg::*;
();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/bsfm_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfm_res_if - result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface bsfm_res_if
  import bsfm_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/bsfm_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfm_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bsfm_cfg_if
  import bsfm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TickW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/bsfm_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfm_in_stage - input register
// Capture one item and hold it until the core consumes it.
// ----------------------------------------------------------------------------
module bsfm_in_stage
  import bsfm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  consume_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  vld_q;
  item_t item_q;

  // Refill when empty or when the held item leaves this cycle
  assign ready_o = !vld_q || consume_i;
  assign valid_o = vld_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

/* sv/bsfm_tx_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfm_tx_buf - transmit byte buffer
// Small register file: one write port, one asynchronous read port.
// ----------------------------------------------------------------------------
module bsfm_tx_buf
  import bsfm_pkg::*;
#(
  parameter int unsigned MaxFrame = MaxFrameDef
) (
  input  logic             clk_i,
  input  buf_wr_t          wr_i,
  input  logic [LenW-1:0]  rd_idx_i,
  output logic [ByteW-1:0] rd_data_o
);

  localparam int unsigned BufDepth = (MaxFrame < LoadSlots) ? MaxFrame : LoadSlots;
  localparam int unsigned IdxW     = (BufDepth > 1) ? $clog2(BufDepth) : 1;

  logic [ByteW-1:0] mem_q [BufDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx[IdxW-1:0]] <= wr_i.data;
    end
  end

  assign rd_data_o = mem_q[rd_idx_i[IdxW-1:0]];

endmodule

/* sv/bsfm_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfm_core - frame sequencing core
// Phase, timer, counters and request flag; decodes one item per cycle while
// fire_i is high, and forms its result.
// ----------------------------------------------------------------------------
module bsfm_core
  import bsfm_pkg::*;
#(
  parameter int unsigned MaxFrame = MaxFrameDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  item_t              item_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TickW-1:0]   cfg_data_i,
  input  logic [ByteW-1:0]   buf_rd_data_i,
  output logic [LenW-1:0]    buf_rd_idx_o,
  output buf_wr_t            buf_wr_o,
  output result_t            res_o
);

  localparam logic [8:0] MaxFrameW = 9'(MaxFrame);

  phase_e          phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic            run_q, run_d;
  logic            line_q, line_d;
  logic [LenW-1:0] send_idx_q, send_idx_d;
  logic [LenW-1:0] send_tot_q, send_tot_d;
  logic [LenW-1:0] recv_idx_q, recv_idx_d;
  logic [LenW-1:0] recv_tot_q, recv_tot_d;
  logic            pend_q, pend_d;
  logic [TickW-1:0] break_ticks_q, timeout_ticks_q;

  logic is_start, is_tick, is_txr, is_rx, is_load, is_ack;
  logic [TickW-1:0] tick_inc, limit;
  logic tick_hit, brk_done, tmo_end;
  logic tx_can, tx_send, tx_stop;
  logic sync_ok, sync_bad;
  logic rx_store, rx_end, req_cap, frame_end;
  logic [LenW-1:0] recv_next, count;

  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] len);
    return ({4'd0, len} > MaxFrameW) ? LenW'(MaxFrame) : len;
  endfunction

  // Opcode decode; unused codes decode to nothing
  always_comb begin
    is_start = 1'b0;
    is_tick  = 1'b0;
    is_txr   = 1'b0;
    is_rx    = 1'b0;
    is_load  = 1'b0;
    is_ack   = 1'b0;
    if (fire_i) begin
      unique case (op_e'(item_i.opcode))
        OpStart:   is_start = 1'b1;
        OpTick:    is_tick  = 1'b1;
        OpTxReady: is_txr   = 1'b1;
        OpRxByte:  is_rx    = 1'b1;
        OpLoad:    is_load  = 1'b1;
        OpReqAck:  is_ack   = 1'b1;
        default:   ;
      endcase
    end
  end

  // Event conditions shared by next state and result
  always_comb begin
    limit     = (phase_q == PhBreak) ? break_ticks_q : timeout_ticks_q;
    tick_inc  = (tick_q == TickMax) ? tick_q : tick_q + 1'b1;
    tick_hit  = is_tick && run_q && (tick_inc >= limit);
    brk_done  = tick_hit && (phase_q == PhBreak);
    tmo_end   = tick_hit && (phase_q != PhBreak);
    tx_can    = (send_idx_q < send_tot_q) && ({4'd0, send_idx_q} < MaxFrameW);
    tx_send   = is_txr && (phase_q != PhBreak) && tx_can;
    tx_stop   = is_txr && (phase_q != PhBreak) && !tx_can;
    sync_ok   = is_rx && (phase_q == PhSync) && (item_i.data_byte == SyncByte);
    sync_bad  = is_rx && (phase_q == PhSync) && (item_i.data_byte != SyncByte);
    rx_store  = is_rx && (phase_q == PhRecv) && (recv_idx_q < recv_tot_q);
    recv_next = rx_store ? recv_idx_q + 1'b1 : recv_idx_q;
    rx_end    = is_rx && (phase_q == PhRecv) && (recv_next >= recv_tot_q);
    req_cap   = is_rx && (phase_q == PhIdle) && !pend_q;
    frame_end = tmo_end || sync_bad || rx_end;
    count     = sync_bad ? '0 : recv_next;
  end

  // Next state
  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    run_d      = run_q;
    line_d     = line_q;
    send_idx_d = send_idx_q;
    send_tot_d = send_tot_q;
    recv_idx_d = recv_idx_q;
    recv_tot_d = recv_tot_q;
    pend_d     = pend_q;

    if (is_start) begin
      phase_d    = PhBreak;
      tick_d     = '0;
      run_d      = 1'b1;
      line_d     = 1'b0;
      send_idx_d = '0;
      recv_idx_d = '0;
      send_tot_d = clamp_len(item_i.tx_length);
      recv_tot_d = clamp_len(item_i.rx_length);
    end
    if (is_tick && run_q) begin
      tick_d = tick_inc;
    end
    if (brk_done) begin
      line_d  = 1'b1;
      tick_d  = '0;
      phase_d = PhSync;
    end
    if (tx_send) begin
      send_idx_d = send_idx_q + 1'b1;
    end
    if (sync_ok) begin
      phase_d = PhRecv;
    end
    if (is_rx && (phase_q == PhRecv)) begin
      tick_d     = '0;
      recv_idx_d = recv_next;
    end
    if (frame_end) begin
      run_d   = 1'b0;
      phase_d = PhIdle;
    end
    if (req_cap) begin
      pend_d = 1'b1;
    end
    if (is_ack) begin
      pend_d = 1'b0;
    end
  end

  // Result of the current item
  always_comb begin
    res_o               = '0;
    res_o.line_high     = line_d;
    res_o.mode          = phase_d;
    res_o.tx_valid      = brk_done || tx_send;
    res_o.tx_stop       = tx_stop;
    if (brk_done) begin
      res_o.tx_byte = SyncByte;
    end else if (tx_send) begin
      res_o.tx_byte = buf_rd_data_i;
    end
    res_o.rx_write      = rx_store;
    res_o.rx_slot       = rx_store ? recv_idx_q[LoadIdxW-1:0] : '0;
    res_o.received_byte = (rx_store || req_cap) ? item_i.data_byte : '0;
    res_o.frame_done    = frame_end;
    res_o.frame_count   = frame_end ? count : '0;
    res_o.request_valid = req_cap;
  end

  assign buf_rd_idx_o = send_idx_q;
  assign buf_wr_o.en   = is_load && ({5'd0, item_i.load_index} < MaxFrameW);
  assign buf_wr_o.idx  = item_i.load_index;
  assign buf_wr_o.data = item_i.data_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      tick_q     <= '0;
      run_q      <= 1'b0;
      line_q     <= 1'b1;
      send_idx_q <= '0;
      send_tot_q <= '0;
      recv_idx_q <= '0;
      recv_tot_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      run_q      <= run_d;
      line_q     <= line_d;
      send_idx_q <= send_idx_d;
      send_tot_q <= send_tot_d;
      recv_idx_q <= recv_idx_d;
      recv_tot_q <= recv_tot_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      break_ticks_q   <= BreakTicksRst;
      timeout_ticks_q <= TimeoutTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgBreakTicks:   break_ticks_q   <= cfg_data_i;
        CfgTimeoutTicks: timeout_ticks_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

endmodule

/* sv/bsfm_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfm_out_stage - result register
// Hold one result until the sink takes it; report when a new one fits.
// ----------------------------------------------------------------------------
module bsfm_out_stage
  import bsfm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    vld_q;
  result_t res_q;

  assign space_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (space_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* sv/break_sync_frame_master.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// break_sync_frame_master - single-wire bus frame master
// Break, sync and response sequencing for one bus frame, driven by events.
// ----------------------------------------------------------------------------
// Every event request (start, tick, transmit ready, received byte, buffer
// load, request acknowledge) returns exactly one result request, in order.
// The block takes one event per clock cycle while results are taken. An
// event is captured in the input register at its accepting edge. Once the
// result register has space it is decoded and applied to the frame state,
// and its result is loaded into the result register at that edge. The result
// register lets intake go on while a result waits; only a stalled result
// with a full input register holds off new events. Configuration (break
// length, response timeout) is written through its own port, always ready,
// and should be changed only while no event is in flight. The transmit
// buffer holds up to sixteen bytes and is not cleared at reset: send only
// slots that were loaded.
// ----------------------------------------------------------------------------
module break_sync_frame_master
  import bsfm_pkg::*;
#(
  parameter int unsigned MaxFrame = MaxFrameDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsfm_item_if.sink    in_i,
  bsfm_res_if.source   res_o,
  bsfm_cfg_if.sink     cfg_i
);

  item_t            item;
  logic             item_vld;
  logic             space;
  logic             fire;
  result_t          res_d;
  buf_wr_t          buf_wr;
  logic [LenW-1:0]  buf_rd_idx;
  logic [ByteW-1:0] buf_rd_data;

  // Advance the held event when the result register can take its result
  assign fire = item_vld && space;

  // Registers take writes in any cycle
  assign cfg_i.ready = 1'b1;

  bsfm_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .item_i    (in_i.payload),
    .consume_i (fire),
    .valid_o   (item_vld),
    .item_o    (item)
  );

  // Transmit bytes loaded by the host, read at the send index
  bsfm_tx_buf #(
    .MaxFrame (MaxFrame)
  ) u_tx_buf (
    .clk_i     (clk_i),
    .wr_i      (buf_wr),
    .rd_idx_i  (buf_rd_idx),
    .rd_data_o (buf_rd_data)
  );

  // Phase, timer and counters; forms the result of the held event
  bsfm_core #(
    .MaxFrame (MaxFrame)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (item),
    .cfg_we_i      (cfg_i.valid),
    .cfg_idx_i     (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .buf_rd_data_i (buf_rd_data),
    .buf_rd_idx_o  (buf_rd_idx),
    .buf_wr_o      (buf_wr),
    .res_o         (res_d)
  );

  // Hold the result until the sink takes it
  bsfm_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .res_i   (res_d),
    .space_o (space),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (res_o.payload)
  );

endmodule

/* sv/bsfm_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfm_chk - port-level checks of the frame master
// Consistency of result fields and hold of a stalled result.
// ----------------------------------------------------------------------------
module bsfm_chk
  import bsfm_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    res_valid_i,
  input logic    res_ready_i,
  input result_t res_i
);

  // The line is low exactly while the break runs
  a_line_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_i.line_high == (res_i.mode != PhBreak)))
    else $error("line level does not match break phase");

  // A finished frame leaves the master idle with no transmit or request
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.frame_done |->
      (res_i.mode == PhIdle) && !res_i.tx_valid && !res_i.tx_stop && !res_i.request_valid)
    else $error("frame end with wrong mode or side outputs");

  // A stored byte is never also a request, and only in receive or at frame end
  a_rx_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.rx_write |->
      !res_i.request_valid && !res_i.tx_valid &&
      ((res_i.mode == PhRecv) || ((res_i.mode == PhIdle) && res_i.frame_done)))
    else $error("receive write in wrong context");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_i))
    else $error("stalled result changed");

endmodule

bind break_sync_frame_master bsfm_chk u_bsfm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_i       (res_o.payload)
);

/* bench/frame_master_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_master_checker - result predictor and scoreboard for the frame master
// Watches the event, result and register channels, predicts one result per
// accepted event request and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module frame_master_checker
  import bsfm_pkg::*;
#(
  parameter int unsigned MaxFrame = MaxFrameDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsfm_item_if        ev_mon,
  bsfm_res_if         res_mon,
  bsfm_cfg_if         cfg_mon,
  output int unsigned mismatch_count_o,
  output int unsigned owed_count_o
);

  // Shadow of the frame state and the two registers
  phase_e              cur_phase;
  logic [TickW-1:0]    ticks;
  logic                timer_on;
  logic                line;
  logic [LenW-1:0]     send_idx;
  logic [LenW-1:0]     send_len;
  logic [LenW-1:0]     recv_idx;
  logic [LenW-1:0]     recv_len;
  logic [ByteW-1:0]    tx_buf [LoadSlots];
  logic                req_held;
  logic [TickW-1:0]    break_len;
  logic [TickW-1:0]    timeout_len;

  result_t     owed_results [$];
  int unsigned errs = 0;

  function automatic logic [LenW-1:0] clip_len(logic [LenW-1:0] n);
    return (n > MaxFrame) ? LenW'(MaxFrame) : n;
  endfunction

  task automatic close_frame(inout result_t r, input logic [LenW-1:0] count);
    timer_on     = 1'b0;
    cur_phase    = PhIdle;
    r.frame_done  = 1'b1;
    r.frame_count = count;
  endtask

  // Advance the shadow state by one event and build the result it produces
  task automatic apply_event(input item_t ev, output result_t r);
    logic [TickW-1:0] limit;
    r = '0;
    case (ev.opcode)
      OpStart: begin
        timer_on  = 1'b1;
        ticks     = '0;
        send_len  = clip_len(ev.tx_length);
        recv_len  = clip_len(ev.rx_length);
        send_idx  = '0;
        recv_idx  = '0;
        line      = 1'b0;
        cur_phase = PhBreak;
      end
      OpTick: begin
        if (timer_on) begin
          limit = (cur_phase == PhBreak) ? break_len : timeout_len;
          if (ticks != TickMax) ticks = ticks + 1'b1;
          if (ticks >= limit) begin
            if (cur_phase == PhBreak) begin
              line       = 1'b1;
              r.tx_valid = 1'b1;
              r.tx_byte  = SyncByte;
              ticks      = '0;
              cur_phase  = PhSync;
            end else begin
              close_frame(r, recv_idx);
            end
          end
        end
      end
      OpTxReady: begin
        if (cur_phase != PhBreak) begin
          if (send_idx < send_len && send_idx < MaxFrame) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = tx_buf[send_idx[LoadIdxW-1:0]];
            send_idx   = send_idx + 1'b1;
          end else begin
            r.tx_stop = 1'b1;
          end
        end
      end
      OpRxByte: begin
        if (cur_phase == PhSync) begin
          if (ev.data_byte != SyncByte) close_frame(r, '0);
          else cur_phase = PhRecv;
        end else if (cur_phase == PhRecv) begin
          if (recv_idx < recv_len) begin
            r.rx_write      = 1'b1;
            r.rx_slot       = recv_idx[LoadIdxW-1:0];
            r.received_byte = ev.data_byte;
            recv_idx        = recv_idx + 1'b1;
          end
          ticks = '0;
          if (recv_idx >= recv_len) close_frame(r, recv_idx);
        end else if (cur_phase == PhIdle && !req_held) begin
          req_held        = 1'b1;
          r.received_byte = ev.data_byte;
          r.request_valid = 1'b1;
        end
      end
      OpLoad: begin
        if (ev.load_index < MaxFrame) tx_buf[ev.load_index] = ev.data_byte;
      end
      OpReqAck: begin
        req_held = 1'b0;
      end
      default: ;
    endcase
    r.line_high = line;
    r.mode      = cur_phase;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endtask

  task automatic compare_result(result_t want, result_t got);
    check_field("line_high", want.line_high, got.line_high);
    check_field("tx_valid", want.tx_valid, got.tx_valid);
    check_field("tx_byte", want.tx_byte, got.tx_byte);
    check_field("tx_stop", want.tx_stop, got.tx_stop);
    check_field("rx_write", want.rx_write, got.rx_write);
    check_field("rx_slot", want.rx_slot, got.rx_slot);
    check_field("received_byte", want.received_byte, got.received_byte);
    check_field("frame_done", want.frame_done, got.frame_done);
    check_field("frame_count", want.frame_count, got.frame_count);
    check_field("request_valid", want.request_valid, got.request_valid);
    check_field("mode", want.mode, got.mode);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      cur_phase   = PhIdle;
      ticks       = '0;
      timer_on    = 1'b0;
      line        = 1'b1;
      send_idx    = '0;
      send_len    = '0;
      recv_idx    = '0;
      recv_len    = '0;
      req_held    = 1'b0;
      break_len   = BreakTicksRst;
      timeout_len = TimeoutTicksRst;
      owed_results.delete();
      owed_count_o <= 0;
    end else begin
      // Retire the result first: it never belongs to an event taken this edge
      if (res_mon.valid && res_mon.ready) begin
        if (owed_results.size() == 0) begin
          $error("result request with no expectation pending");
          errs++;
        end else begin
          want = owed_results.pop_front();
          compare_result(want, res_mon.payload);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CfgBreakTicks:   break_len   = cfg_mon.data;
          CfgTimeoutTicks: timeout_len = cfg_mon.data;
          default: ;
        endcase
      end
      if (ev_mon.valid && ev_mon.ready) begin
        apply_event(ev_mon.payload, want);
        owed_results.push_back(want);
      end
      owed_count_o <= owed_results.size();
    end
    mismatch_count_o <= errs;
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - frame master stimulus and verdict
// Drives directed frames, then long runs of randomized bus frames under
// several break and timeout settings with random stalls on both channels;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import bsfm_pkg::*;

  // Opcodes with no function in the block
  localparam logic [OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;

  localparam int unsigned ItemsTotal  = 1150;
  localparam int unsigned NumSettings = 6;

  // Break and timeout settings for the random phases, extremes included;
  // the huge break phase stays short since its break never completes
  localparam logic [TickW-1:0] BreakSet   [NumSettings] =
    '{16'd1, 16'd4, 16'd65535, 16'd9, 16'd2, 16'd1};
  localparam logic [TickW-1:0] TimeoutSet [NumSettings] =
    '{16'd1, 16'd6, 16'd65535, 16'd2, 16'd25, 16'd65535};
  localparam int unsigned      QuotaSet   [NumSettings] = '{200, 220, 40, 220, 220, 220};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  bsfm_item_if ev_if ();
  bsfm_res_if  res_if ();
  bsfm_cfg_if  cfg_if ();

  int unsigned mismatches;
  int unsigned results_owed;

  break_sync_frame_master uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (ev_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  frame_master_checker chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .ev_mon           (ev_if),
    .res_mon          (res_if),
    .cfg_mon          (cfg_if),
    .mismatch_count_o (mismatches),
    .owed_count_o     (results_owed)
  );

  // Stimulus-side knowledge: which transmit slots hold data, current register
  // values, request count and stall percentages for both sides
  logic [LoadSlots-1:0] loaded = '0;
  int unsigned brk_len  = BreakTicksRst;
  int unsigned tout_len = TimeoutTicksRst;
  int unsigned sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  int unsigned long_hold_cycles = 0;
  bit          long_hold_done = 1'b0;

  function automatic item_t ev(logic [OpW-1:0] op, logic [ByteW-1:0] data = '0,
                               logic [LoadIdxW-1:0] idx = '0,
                               logic [LenW-1:0] txl = '0, logic [LenW-1:0] rxl = '0);
    item_t it;
    it.opcode     = op;
    it.data_byte  = data;
    it.load_index = idx;
    it.tx_length  = txl;
    it.rx_length  = rxl;
    return it;
  endfunction

  // Never ask for more bytes than the loaded run of slots from slot 0, so no
  // unwritten slot is ever sent; once all are loaded, any length goes
  function automatic logic [LenW-1:0] pick_tx_len();
    int unsigned ready_slots;
    ready_slots = 0;
    while (ready_slots < LoadSlots && loaded[ready_slots]) ready_slots++;
    if (ready_slots == LoadSlots) return LenW'($urandom_range((1 << LenW) - 1));
    return LenW'($urandom_range(ready_slots));
  endfunction

  // Offer one event request, with random gaps ahead of it; leave valid high
  // so back-to-back requests need no extra edge
  task automatic offer_event(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      ev_if.valid <= 1'b0;
      @(posedge clk);
    end
    ev_if.valid   <= 1'b1;
    ev_if.payload <= it;
    do @(posedge clk); while (!ev_if.ready);
    if (it.opcode == OpLoad) loaded[it.load_index] = 1'b1;
    sent++;
  endtask

  // Drop valid and hold until every predicted result has been taken; the
  // owed count is registered, so keep waiting after it reads zero before trusting it
  task automatic settle();
    ev_if.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (3) @(posedge clk);
  endtask

  // Write both registers back to back; call only with the block drained
  task automatic write_settings(logic [TickW-1:0] brk, logic [TickW-1:0] tout);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CfgBreakTicks;
    cfg_if.data  <= brk;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= CfgTimeoutTicks;
    cfg_if.data  <= tout;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    brk_len  = brk;
    tout_len = tout;
  endtask

  function automatic item_t noise_event();
    item_t it;
    it = item_t'({$urandom, $urandom});
    if (it.opcode == OpStart) it.tx_length = pick_tx_len();
    return it;
  endfunction

  // One frame with random content: loads, start, break ticks, sync echo,
  // response bytes with interleaved ticks and transmit-ready requests, then
  // idle-mode request traffic, with spare opcodes and random noise now and then
  task automatic run_frame();
    logic [LenW-1:0]  txl, rxl;
    logic [ByteW-1:0] bad;
    int unsigned      rx_lim, nticks, nrx;
    repeat ($urandom_range(3))
      offer_event(ev(OpLoad, ByteW'($urandom), LoadIdxW'($urandom)));
    txl = pick_tx_len();
    rxl = ($urandom_range(9) == 0) ? LenW'($urandom_range(31)) : LenW'($urandom_range(16));
    offer_event(ev(OpStart, ByteW'($urandom), LoadIdxW'($urandom), txl, rxl));

    // Events that the break must ignore
    if ($urandom_range(5) == 0)
      offer_event(ev($urandom_range(1) ? OpTxReady : OpRxByte, ByteW'($urandom)));

    // Run the break out, now and then cut it short
    if (brk_len <= 40)
      nticks = ($urandom_range(7) == 0) ? $urandom_range(brk_len) : brk_len;
    else
      nticks = $urandom_range(1, 6);
    repeat (nticks) offer_event(ev(OpTick));

    // Echo the sync byte, mostly good
    bad = ByteW'($urandom);
    if (bad == SyncByte) bad = ~bad;
    offer_event(ev(OpRxByte, ($urandom_range(9) == 0) ? bad : SyncByte));

    rx_lim = (rxl > MaxFrameDef) ? MaxFrameDef : rxl;
    nrx    = $urandom_range(rx_lim + 1);
    repeat (nrx) begin
      if ($urandom_range(4) < 2) offer_event(ev(OpTxReady));
      if (tout_len > 3 && $urandom_range(2) == 0)
        repeat ($urandom_range(2)) offer_event(ev(OpTick));
      offer_event(ev(OpRxByte, ByteW'($urandom)));
    end

    // Let the response time out now and then
    if (tout_len <= 40 && $urandom_range(3) == 0)
      repeat (tout_len) offer_event(ev(OpTick));
    repeat ($urandom_range(2)) offer_event(ev(OpTxReady));

    if ($urandom_range(1)) offer_event(ev(OpRxByte, ByteW'($urandom)));
    if ($urandom_range(2) != 0) offer_event(ev(OpReqAck));
    if ($urandom_range(15) == 0)
      offer_event(ev($urandom_range(1) ? OpSpareLo : OpSpareHi, ByteW'($urandom)));
    if ($urandom_range(9) == 0) offer_event(noise_event());

    // Pause the sender until everything is back, once in a while
    if ($urandom_range(49) == 0) settle();
  endtask

  // Result side: accept at random, or hold off for a long stretch on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_cycles > 0) begin
        res_if.ready <= 1'b0;
        long_hold_cycles--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  initial begin
    ev_if.valid   = 1'b0;
    ev_if.payload = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CfgBreakTicks;
    cfg_if.data   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 24;
    take_idle_pct = 55;

    // Directed: idle behavior under the reset register values
    offer_event(ev(OpTxReady));            // nothing to send: stop
    offer_event(ev(OpTick));               // timer stopped: ignored
    offer_event(ev(OpSpareHi, 8'hFF, 4'hF, 5'h1F, 5'h1F));
    offer_event(ev(OpRxByte, 8'hFF));      // request captured
    offer_event(ev(OpRxByte, 8'h00));      // request pending: ignored
    offer_event(ev(OpReqAck));
    offer_event(ev(OpReqAck));             // nothing pending
    offer_event(ev(OpLoad, 8'hFF, 4'h0));
    offer_event(ev(OpLoad, 8'h00, 4'h1));
    offer_event(ev(OpLoad, 8'hA5, 4'hF));

    settle();
    write_settings(16'd2, 16'd3);

    // Directed: saturated receive length, events during the break, sync,
    // buffered bytes, transmit stop and a response timeout
    offer_event(ev(OpStart, 8'h00, 4'h0, 5'd2, 5'd31));
    offer_event(ev(OpRxByte, 8'h55));
    offer_event(ev(OpTxReady));
    offer_event(ev(OpTick));
    offer_event(ev(OpTick));
    offer_event(ev(OpTxReady));
    offer_event(ev(OpTxReady));
    offer_event(ev(OpTxReady));
    offer_event(ev(OpRxByte, SyncByte));
    offer_event(ev(OpRxByte, 8'hFF));
    repeat (3) offer_event(ev(OpTick));

    // Directed: restart a running frame, then zero receive length
    offer_event(ev(OpStart, 8'h00, 4'h0, 5'd0, 5'd0));
    offer_event(ev(OpTick));
    offer_event(ev(OpStart, 8'h00, 4'h0, 5'd0, 5'd0));
    offer_event(ev(OpTick));
    offer_event(ev(OpTick));
    offer_event(ev(OpRxByte, SyncByte));
    offer_event(ev(OpRxByte, 8'h12));

    // Directed: bad sync ends the frame with no bytes
    offer_event(ev(OpStart, 8'h00, 4'h0, 5'd1, 5'd16));
    offer_event(ev(OpTick));
    offer_event(ev(OpTick));
    offer_event(ev(OpRxByte, 8'h00));

    // Random phases, one per register setting
    for (int p = 0; p < NumSettings; p++) begin
      int unsigned stop_at;
      settle();
      write_settings(BreakSet[p], TimeoutSet[p]);
      stop_at = sent + QuotaSet[p];
      while (sent < stop_at) begin
        // Sender idles less than the receiver first, then the other way
        // round, and in the last third neither idles
        if (sent < ItemsTotal / 3) begin
          send_idle_pct = 24;
          take_idle_pct = 55;
        end else if (sent < 2 * ItemsTotal / 3) begin
          send_idle_pct = 55;
          take_idle_pct = 24;
        end else begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
        // Stall results long enough to fill the block and back up intake
        if (!long_hold_done && sent >= ItemsTotal / 2) begin
          long_hold_done   = 1'b1;
          long_hold_cycles = 300;
        end
        run_frame();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
